FILE: rtl/mafq_pkg.sv
// ----------------------------------------------------------------------------
// mafq_pkg: shared types and arithmetic helpers
// Sequencer states, datapath operation codes and the quantizer functions
// used by the moving-average filter with quantized multiply-accumulate.
// ----------------------------------------------------------------------------
package mafq_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned WeightW = 17;
  localparam int unsigned CountW  = 5;
  localparam int unsigned QuantW  = 16;
  localparam int unsigned WideW   = 38;

  // Index of each configuration register.
  localparam logic CfgTapCount  = 1'b0;
  localparam logic CfgTapWeight = 1'b1;

  localparam logic [CountW-1:0]  TapCountRst  = 5'd16;
  localparam logic [WeightW-1:0] TapWeightRst = 17'd4096;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QX,
    ST_MUL,
    ST_SCL,
    ST_CLS,
    ST_QNT,
    ST_ADD,
    ST_EMIT
  } seq_state_e;

  typedef enum logic [2:0] {
    MOP_NONE,
    MOP_CLEAR,
    MOP_QX,
    MOP_MUL,
    MOP_SCL,
    MOP_CLS,
    MOP_QNT,
    MOP_ADD
  } mac_op_e;

  // Magnitude of a two's complement word; the most negative value maps to 2^31.
  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  // Magnitude class: 1 up to one in Q15.16, otherwise position of the top bit minus 15.
  function automatic logic [4:0] kclass(input logic [31:0] mag);
    logic [4:0] k;
    k = 5'd1;
    if (mag > 32'd65536) begin
      for (int i = 16; i < 32; i++) begin
        if (mag[i]) k = 5'(i - 15);
      end
    end
    return k;
  endfunction

  // Divide a magnitude by 2^s, rounding half up; s is at least one.
  function automatic logic [31:0] rnd_mag(input logic [31:0] mag, input logic [4:0] s);
    logic [32:0] sum;
    sum = {1'b0, mag} + (33'd1 << (s - 5'd1));
    return 32'(sum >> s);
  endfunction

  // Round a signed value half away from zero at s fraction bits, wrap to 16 bits.
  function automatic logic [15:0] quant16(input logic signed [31:0] v, input logic [4:0] s);
    logic [31:0] r;
    r = rnd_mag(mag32(v), s);
    return v[31] ? 16'(~r[15:0] + 16'd1) : r[15:0];
  endfunction

  function automatic logic [31:0] sat32(input logic signed [WideW-1:0] v);
    logic [31:0] r;
    if (v > 38'sd2147483647) r = 32'h7FFF_FFFF;
    else if (v < -38'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

FILE: rtl/mafq_window.sv
// ----------------------------------------------------------------------------
// mafq_window: sample history
// Shift line of the most recent samples, newest at entry zero, with one
// read port addressed by the sequencer.
// ----------------------------------------------------------------------------
module mafq_window #(
  parameter int unsigned Depth = 16,
  parameter int unsigned IdxW  = 4
) (
  input  logic        clk_i,
  input  logic        shift_i,
  input  logic [31:0] din_i,
  input  logic [IdxW-1:0] rd_idx_i,
  output logic [31:0] rd_data_o
);
  import mafq_pkg::*;

  logic [31:0] win_q [Depth];

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      win_q[0] <= din_i;
      for (int i = 1; i < Depth; i++) begin
        win_q[i] <= win_q[i-1];
      end
    end
  end

  assign rd_data_o = win_q[rd_idx_i];

endmodule

FILE: rtl/mafq_mac.sv
// ----------------------------------------------------------------------------
// mafq_mac: shared quantized multiply-accumulate unit
// One term takes six operations: quantize the sample, multiply, rescale the
// product, find the common class, quantize both addends, add and rescale.
// ----------------------------------------------------------------------------
module mafq_mac (
  input  logic                 clk_i,
  input  mafq_pkg::mac_op_e    op_i,
  input  logic signed [31:0]   sample_i,
  input  logic [16:0]          weight_i,
  output logic signed [31:0]   acc_o
);
  import mafq_pkg::*;

  logic [15:0]        m_q, m_d;
  logic [4:0]         e_q, e_d;
  logic               neg_q, neg_d;
  logic signed [31:0] o_q, o_d;
  logic signed [31:0] p_q, p_d;
  logic [4:0]         ea_q, ea_d;
  logic [15:0]        qa_q, qa_d, qp_q, qp_d;
  logic signed [31:0] acc_q, acc_d;

  logic [15:0]            n_w;
  logic [31:0]            xmag;
  logic [4:0]             kx, ka, kp, sh;
  logic [31:0]            om, rm;
  logic signed [WideW-1:0] r;
  logic signed [16:0]     sum17;

  // The weight is under two in Q15.16, so its class is always one.
  assign n_w = 16'(rnd_mag({15'd0, weight_i}, 5'd3));

  always_comb begin
    m_d   = m_q;
    e_d   = e_q;
    neg_d = neg_q;
    o_d   = o_q;
    p_d   = p_q;
    ea_d  = ea_q;
    qa_d  = qa_q;
    qp_d  = qp_q;
    acc_d = acc_q;
    xmag  = mag32(sample_i);
    kx    = kclass(xmag);
    ka    = kclass(mag32(acc_q));
    kp    = kclass(mag32(p_q));
    sh    = 5'd12 - e_q;
    om    = mag32(o_q);
    rm    = rnd_mag(om, sh);
    r     = '0;
    sum17 = $signed({qa_q[15], qa_q}) + $signed({qp_q[15], qp_q});
    unique case (op_i)
      MOP_NONE: ;
      MOP_CLEAR: acc_d = '0;
      MOP_QX: begin
        m_d   = 16'(rnd_mag(xmag, kx + 5'd2));
        e_d   = kx + 5'd1;
        neg_d = sample_i[31] && (weight_i != '0);
      end
      MOP_MUL: o_d = $signed(m_q) * $signed(n_w);
      MOP_SCL: begin
        if (e_q >= 5'd12) begin
          r = WideW'(o_q) <<< (e_q - 5'd12);
        end else begin
          r = $signed({6'd0, rm});
          if (o_q[31]) r = -r;
        end
        if (neg_q) r = -r;
        p_d = sat32(r);
      end
      MOP_CLS: ea_d = (ka > kp) ? ka : kp;
      MOP_QNT: begin
        qa_d = quant16(acc_q, ea_q + 5'd2);
        qp_d = quant16(p_q, ea_q + 5'd2);
      end
      MOP_ADD: begin
        r     = WideW'(sum17) <<< (ea_q + 5'd2);
        acc_d = sat32(r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    m_q   <= m_d;
    e_q   <= e_d;
    neg_q <= neg_d;
    o_q   <= o_d;
    p_q   <= p_d;
    ea_q  <= ea_d;
    qa_q  <= qa_d;
    qp_q  <= qp_d;
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

FILE: rtl/moving_average_fir_quantized_mac.sv
// ----------------------------------------------------------------------------
// moving_average_fir_quantized_mac: moving-average FIR with quantized MAC
// Full convolution of a sample stream with equal taps, every product and
// partial sum passing through a magnitude-scaled 16-bit quantizer.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: sample_i and is_last_i, taken when in_valid_i is high and
//   in_stall_o is low. Output channel: filtered_o and last_out_o, taken when
//   out_valid_o is high and out_stall_i is low. Every item gives one result;
//   an item with is_last_i set gives tap_count results, the last one marked.
//   Each result sums n terms (n up to tap_count) on one shared multiply-
//   accumulate unit, six operations a term, after the idle state accepts
//   the item; the emit state then hands the sum to the output register.
//   in_stall_o stays high while an item is at work. A result waiting in the
//   output register does not block the next item; the sequencer waits only
//   when a new result is ready and the register is full and stalled.
//   Reset clears the sequencer, the sample count and the output valid flag
//   and loads sixteen taps of 1/16. Configuration must be written only
//   while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module moving_average_fir_quantized_mac #(
  parameter int unsigned MAX_TAPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [16:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] sample_i,
  input  logic               is_last_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] filtered_o,
  output logic               last_out_o
);
  import mafq_pkg::*;

  localparam int unsigned IdxW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int unsigned CntW = $clog2(MAX_TAPS + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_TAPS);

  seq_state_e state_q, state_d;
  mac_op_e    mac_op;

  logic [CountW-1:0]  tap_count_q;
  logic [WeightW-1:0] tap_weight_q;
  logic [CntW-1:0]    seen_q, seen_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [CntW-1:0]    t_q, t_d;
  logic [IdxW-1:0]    d_q, d_d;
  logic               last_q, last_d;
  logic               out_valid_q, out_valid_d;
  logic signed [31:0] filtered_q;
  logic               last_out_q;

  logic [CntW-1:0]    taps_eff, seen_inc, cnt_new, t_next, lim, hi_next;
  logic               accept, slot_free, more, load_out;
  logic [31:0]        win_data;
  logic signed [31:0] acc;

  assign accept    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign slot_free = !out_valid_q || !out_stall_i;
  assign more      = last_q && ((t_q + CntW'(1)) < taps_eff);

  always_comb begin
    if (tap_count_q == '0) taps_eff = CntW'(1);
    else if (32'(tap_count_q) > 32'(MAX_TAPS)) taps_eff = MaxCnt;
    else taps_eff = CntW'(tap_count_q);
    seen_inc = (seen_q < MaxCnt) ? seen_q + CntW'(1) : seen_q;
    cnt_new  = (seen_inc < taps_eff) ? seen_inc : taps_eff;
    t_next   = t_q + CntW'(1);
    lim      = taps_eff - CntW'(1) - t_next;
    hi_next  = (lim < cnt_q - CntW'(1)) ? lim : cnt_q - CntW'(1);
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q  <= TapCountRst;
      tap_weight_q <= TapWeightRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgTapCount:  tap_count_q  <= cfg_data_i[CountW-1:0];
        CfgTapWeight: tap_weight_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_QX;
      ST_QX:   state_d = ST_MUL;
      ST_MUL:  state_d = ST_SCL;
      ST_SCL:  state_d = ST_CLS;
      ST_CLS:  state_d = ST_QNT;
      ST_QNT:  state_d = ST_ADD;
      ST_ADD:  state_d = (d_q == '0) ? ST_EMIT : ST_QX;
      ST_EMIT: if (slot_free) state_d = more ? ST_QX : ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs and counters.
  always_comb begin
    mac_op   = MOP_NONE;
    seen_d   = seen_q;
    cnt_d    = cnt_q;
    t_d      = t_q;
    d_d      = d_q;
    last_d   = last_q;
    load_out = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          mac_op = MOP_CLEAR;
          seen_d = is_last_i ? '0 : seen_inc;
          cnt_d  = cnt_new;
          last_d = is_last_i;
          t_d    = '0;
          d_d    = IdxW'(cnt_new - CntW'(1));
        end
      end
      ST_QX:  mac_op = MOP_QX;
      ST_MUL: mac_op = MOP_MUL;
      ST_SCL: mac_op = MOP_SCL;
      ST_CLS: mac_op = MOP_CLS;
      ST_QNT: mac_op = MOP_QNT;
      ST_ADD: begin
        mac_op = MOP_ADD;
        if (d_q != '0) d_d = d_q - IdxW'(1);
      end
      ST_EMIT: begin
        if (slot_free) begin
          load_out = 1'b1;
          if (more) begin
            mac_op = MOP_CLEAR;
            t_d    = t_next;
            d_d    = IdxW'(hi_next);
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_d = load_out || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seen_q      <= '0;
      cnt_q       <= '0;
      t_q         <= '0;
      d_q         <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seen_q      <= seen_d;
      cnt_q       <= cnt_d;
      t_q         <= t_d;
      d_q         <= d_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      filtered_q <= acc;
      last_out_q <= last_q && (t_q == taps_eff - CntW'(1));
    end
  end

  mafq_window #(
    .Depth (MAX_TAPS),
    .IdxW  (IdxW)
  ) u_window (
    .clk_i     (clk_i),
    .shift_i   (accept),
    .din_i     (sample_i),
    .rd_idx_i  (d_q),
    .rd_data_o (win_data)
  );

  mafq_mac u_mac (
    .clk_i    (clk_i),
    .op_i     (mac_op),
    .sample_i ($signed(win_data)),
    .weight_i (tap_weight_q),
    .acc_o    (acc)
  );

  assign out_valid_o = out_valid_q;
  assign filtered_o  = filtered_q;
  assign last_out_o  = last_out_q;

  // An accepted item always starts a term on the shared unit.
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_QX))
    else $error("accepted item did not start a term");

  // The window index never reaches beyond the samples held for this result.
  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (CntW'(d_q) < cnt_q))
    else $error("window index beyond valid samples");

  // The result counter stays within the tap count while busy.
  a_result_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (t_q < taps_eff))
    else $error("result counter beyond tap count");

  // A full, stalled output register holds the finished sum back.
  a_emit_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && out_valid_q && out_stall_i) |=> (state_q == ST_EMIT))
    else $error("result left while output register was full");

  a_seen_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= MaxCnt)
    else $error("sample count beyond window depth");

endmodule
